// File: src/ufe_pkg.sv
// Shared types and constants for the union-find engine.
// Used by the channel interfaces and by union_find_engine_core.
`timescale 1ns / 1ps

package ufe_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int ELEM_W       = 10;
  localparam int COUNT_W      = 11;
  localparam int SIZE_W       = ADDR_W + 1;

  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = COUNT_W'(1024);

  localparam logic CMD_UNITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
  } ufe_item_t;

  typedef struct packed {
    logic               already_joined;
    logic               merged;
    logic [ELEM_W-1:0]  root_a;
    logic [COUNT_W-1:0] set_size_a;
    logic               bad_index;
  } ufe_result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_COMP,
    S_SZA,
    S_SZB,
    S_RESULT
  } ufe_state_e;

endpackage

// File: src/ufe_item_if.sv
// Input item channel: valid/ready handshake carrying one command item.
// Depends on ufe_pkg for the payload type.
`timescale 1ns / 1ps

interface ufe_item_if;
  import ufe_pkg::*;

  logic      valid;
  logic      ready;
  ufe_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ufe_result_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on ufe_pkg for the payload type.
`timescale 1ns / 1ps

interface ufe_result_if;
  import ufe_pkg::*;

  logic        valid;
  logic        ready;
  ufe_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ufe_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying element_count.
// Depends on ufe_pkg for the data width.
`timescale 1ns / 1ps

interface ufe_cfg_if;
  import ufe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/union_find_engine_core.sv
// Union-find engine: union by size with full path compression.
// Depends on ufe_pkg and the ufe_item_if, ufe_result_if and ufe_cfg_if interfaces.
//
// Usage:
//   item_i   takes one item {cmd, elem_a, elem_b}; cmd 0 unites, 1 only queries.
//   result_o gives one result per item {already_joined, merged, root_a,
//            set_size_a, bad_index}, in item order.
//   cfg_i    writes element_count; it is always ready. A write restarts the
//            element tables (every element its own set of size one).
// The parent and size tables live in two 1024-entry synchronous RAMs with one
// read and one write port each.
// The path depth of an element stays at most log2 of the element count under
// union by size. A rejected index skips the root walks and goes straight to the
// result.
// One item is in flight at a time; the next item is taken as soon as the
// previous result sits in the output register, even if that result is still
// waiting. A stall on result_o holds the engine in its final step.
// After reset, and after every cfg_i transfer, a clearing pass rewrites both
// tables while item_i.ready stays low.
`timescale 1ns / 1ps

module union_find_engine_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  ufe_item_if.sink      item_i,
  ufe_result_if.source  result_o,
  ufe_cfg_if.sink       cfg_i
);
  import ufe_pkg::*;

  // State machine and working registers
  ufe_state_e         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [ADDR_W-1:0]  cur_q, cur_d;
  logic [ADDR_W-1:0]  start_q, start_d;
  logic [ADDR_W-1:0]  root_q, root_d;
  logic [ADDR_W-1:0]  ra_q, ra_d;
  logic [ADDR_W-1:0]  rb_q, rb_d;
  logic [SIZE_W-1:0]  sza_q, sza_d;
  logic [SIZE_W-1:0]  szb_q, szb_d;
  logic               second_q, second_d;
  logic               bad_q, bad_d;
  logic [COUNT_W-1:0] cnt_q;

  ufe_item_t          item_q;
  ufe_result_t        res_q, res_d;
  logic               res_valid_q;
  logic               res_load;

  logic               item_fire, cfg_fire, out_free;
  logic [COUNT_W-1:0] cnt_eff;
  logic               bad_now;
  logic               fin;
  logic [ADDR_W-1:0]  fin_root;
  logic               joined, do_merge, swap;
  logic [ADDR_W-1:0]  win, lose;
  logic [SIZE_W-1:0]  sum;

  // Parent RAM
  logic [ADDR_W-1:0]  par_mem [MAX_ELEMENTS];
  logic               par_re, par_we;
  logic [ADDR_W-1:0]  par_raddr, par_waddr, par_wdata;
  logic [ADDR_W-1:0]  par_rd_q, par_fwd_data_q, par_rdata;
  logic               par_fwd_q;

  // Size RAM
  logic [SIZE_W-1:0]  sz_mem [MAX_ELEMENTS];
  logic               sz_re, sz_we;
  logic [ADDR_W-1:0]  sz_raddr, sz_waddr;
  logic [SIZE_W-1:0]  sz_wdata;
  logic [SIZE_W-1:0]  sz_rd_q, sz_fwd_data_q, sz_rdata;
  logic               sz_fwd_q;

  assign item_fire = item_i.valid && item_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign out_free  = !res_valid_q || result_o.ready;

  assign cfg_i.ready    = 1'b1;
  assign item_i.ready   = (state_q == S_IDLE);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  assign cnt_eff = (cnt_q > COUNT_W'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS) : cnt_q;
  assign bad_now = (COUNT_W'(item_q.elem_a) >= cnt_eff) ||
                   (COUNT_W'(item_q.elem_b) >= cnt_eff);

  assign joined   = (ra_q == rb_q);
  assign do_merge = (item_q.cmd == CMD_UNITE) && !joined;
  assign swap     = (sza_q < szb_q);
  assign win      = swap ? rb_q : ra_q;
  assign lose     = swap ? ra_q : rb_q;
  assign sum      = sza_q + szb_q;

  // Read data with forwarding of a write to the same entry in the read cycle
  assign par_rdata = par_fwd_q ? par_fwd_data_q : par_rd_q;
  assign sz_rdata  = sz_fwd_q ? sz_fwd_data_q : sz_rd_q;

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (par_re) begin
      par_rd_q       <= par_mem[par_raddr];
      par_fwd_q      <= par_we && (par_waddr == par_raddr);
      par_fwd_data_q <= par_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) begin
      sz_mem[sz_waddr] <= sz_wdata;
    end
    if (sz_re) begin
      sz_rd_q       <= sz_mem[sz_raddr];
      sz_fwd_q      <= sz_we && (sz_waddr == sz_raddr);
      sz_fwd_data_q <= sz_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      second_q    <= 1'b0;
      bad_q       <= 1'b0;
      cnt_q       <= ELEMENT_COUNT_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      second_q <= second_d;
      bad_q    <= bad_d;
      if (cfg_fire) begin
        cnt_q <= cfg_i.data;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    start_q <= start_d;
    root_q  <= root_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    sza_q   <= sza_d;
    szb_q   <= szb_d;
    if (item_fire) begin
      item_q <= item_i.data;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    start_d   = start_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    sza_d     = sza_q;
    szb_d     = szb_q;
    second_d  = second_q;
    bad_d     = bad_q;
    par_re    = 1'b0;
    par_raddr = cur_q;
    par_we    = 1'b0;
    par_waddr = cur_q;
    par_wdata = root_q;
    sz_re     = 1'b0;
    sz_raddr  = ra_q;
    sz_we     = 1'b0;
    sz_waddr  = win;
    sz_wdata  = sum;
    fin       = 1'b0;
    fin_root  = root_q;
    res_load  = 1'b0;
    res_d     = '0;

    case (state_q)
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_q;
        par_wdata = clr_q;
        sz_we     = 1'b1;
        sz_waddr  = clr_q;
        sz_wdata  = SIZE_W'(1);
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_fire) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        bad_d = bad_now;
        if (bad_now) begin
          state_d = S_RESULT;
        end else begin
          // start the root walk of the first element
          second_d  = 1'b0;
          start_d   = item_q.elem_a[ADDR_W-1:0];
          cur_d     = item_q.elem_a[ADDR_W-1:0];
          par_re    = 1'b1;
          par_raddr = item_q.elem_a[ADDR_W-1:0];
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        if (par_rdata == cur_q) begin
          root_d = cur_q;
          if (start_q == cur_q) begin
            fin      = 1'b1;
            fin_root = cur_q;
          end else begin
            // rewalk from the start and point each entry at the root
            cur_d     = start_q;
            par_re    = 1'b1;
            par_raddr = start_q;
            state_d   = S_COMP;
          end
        end else begin
          cur_d     = par_rdata;
          par_re    = 1'b1;
          par_raddr = par_rdata;
        end
      end
      S_COMP: begin
        par_we    = 1'b1;
        par_waddr = cur_q;
        par_wdata = root_q;
        if (par_rdata == root_q) begin
          fin      = 1'b1;
          fin_root = root_q;
        end else begin
          cur_d     = par_rdata;
          par_re    = 1'b1;
          par_raddr = par_rdata;
        end
      end
      S_SZA: begin
        sza_d = sz_rdata;
        szb_d = '0;
        if ((item_q.cmd == CMD_UNITE) && (ra_q != rb_q)) begin
          sz_re    = 1'b1;
          sz_raddr = rb_q;
          state_d  = S_SZB;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SZB: begin
        szb_d   = sz_rdata;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          if (bad_q) begin
            res_d.bad_index = 1'b1;
          end else begin
            res_d.already_joined = joined;
            res_d.merged         = do_merge;
            res_d.root_a         = ELEM_W'(do_merge ? win : ra_q);
            res_d.set_size_a     = COUNT_W'(do_merge ? sum : sza_q);
            if (do_merge) begin
              // link the smaller root under the larger
              par_we    = 1'b1;
              par_waddr = lose;
              par_wdata = win;
              sz_we     = 1'b1;
              sz_waddr  = win;
              sz_wdata  = sum;
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase

    if (fin) begin
      if (!second_q) begin
        // first root found: walk the second element
        ra_d      = fin_root;
        second_d  = 1'b1;
        start_d   = item_q.elem_b[ADDR_W-1:0];
        cur_d     = item_q.elem_b[ADDR_W-1:0];
        par_re    = 1'b1;
        par_raddr = item_q.elem_b[ADDR_W-1:0];
        state_d   = S_WALK;
      end else begin
        rb_d     = fin_root;
        sz_re    = 1'b1;
        sz_raddr = ra_q;
        state_d  = S_SZA;
      end
    end

    if (cfg_fire) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_item_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire && !cfg_fire |=> state_q == S_CHECK)
    else $error("accepted item did not start the index check");

  a_cfg_restarts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> state_q == S_CLEAR && clr_q == '0)
    else $error("configuration write did not restart the clearing pass");

  a_comp_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    par_we && state_q == S_COMP |-> par_wdata != par_waddr)
    else $error("path compression wrote a root entry");

  a_size_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sz_we && state_q == S_RESULT |-> sz_wdata <= SIZE_W'(MAX_ELEMENTS) && sz_wdata > sza_q)
    else $error("merged set size out of range");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free && state_q == S_RESULT)
    else $error("result loaded over a waiting result");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for union_find_engine_core: directed, tree-building and random items.
// Predicts each result with its own parent/size tables.
// Depends on ufe_pkg and the channel interfaces.
`timescale 1ns / 1ps

module testbench;
  import ufe_pkg::*;

  localparam int ITEM_TARGET = 1000;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk;
  logic rst_n;

  ufe_item_if   item_if();
  ufe_result_if result_if();
  ufe_cfg_if    cfg_if();

  union_find_engine_core i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Predicted disjoint-set state
  logic [ELEM_W-1:0]  parent_of   [MAX_ELEMENTS];
  logic [COUNT_W-1:0] set_size_of [MAX_ELEMENTS];
  logic [COUNT_W-1:0] live_count;

  ufe_result_t awaited_results[$];
  int mismatch_count  = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int quiet_cycles    = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int rx_cycle        = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void restart_tables();
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      parent_of[i]   = ELEM_W'(i);
      set_size_of[i] = COUNT_W'(1);
    end
  endfunction

  function automatic int in_use();
    return (live_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(live_count);
  endfunction

  // Walk to the root, then point every visited element straight at it
  function automatic logic [ELEM_W-1:0] root_of(input logic [ELEM_W-1:0] idx);
    logic [ELEM_W-1:0] top;
    logic [ELEM_W-1:0] walk;
    logic [ELEM_W-1:0] nxt;
    top = idx;
    while (parent_of[top] != top) top = parent_of[top];
    walk = idx;
    while (walk != top) begin
      nxt = parent_of[walk];
      parent_of[walk] = top;
      walk = nxt;
    end
    return top;
  endfunction

  function automatic ufe_result_t resolve_item(input ufe_item_t it);
    ufe_result_t res;
    logic [ELEM_W-1:0] ra;
    logic [ELEM_W-1:0] rb;
    logic [ELEM_W-1:0] swap;
    int lim;
    res = '0;
    lim = in_use();
    if (it.elem_a >= lim || it.elem_b >= lim) begin
      res.bad_index = 1'b1;
      return res;
    end
    ra = root_of(it.elem_a);
    rb = root_of(it.elem_b);
    res.already_joined = (ra == rb);
    if (it.cmd == CMD_UNITE && ra != rb) begin
      // smaller set goes under the larger; on a tie the first root stays
      if (set_size_of[ra] < set_size_of[rb]) begin
        swap = ra;
        ra = rb;
        rb = swap;
      end
      parent_of[rb] = ra;
      set_size_of[ra] = set_size_of[ra] + set_size_of[rb];
      res.merged = 1'b1;
    end
    res.root_a = ra;
    res.set_size_a = set_size_of[ra];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("tb: mismatch on result %0d: %s got %0d expected %0d",
             results_checked, what, got, want);
  endtask

  // Valid stays high after a transfer; callers drop it through pause or settle
  task automatic send_item(input ufe_item_t it);
    ufe_result_t predicted;
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
    predicted = resolve_item(it);
    awaited_results = {awaited_results, predicted};
    items_sent++;
  endtask

  task automatic send_cmd(input logic cmd, input int a, input int b);
    ufe_item_t it;
    it.cmd    = cmd;
    it.elem_a = ELEM_W'(a);
    it.elem_b = ELEM_W'(b);
    send_item(it);
  endtask

  task automatic pause_sender(input int cycles);
    item_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic settle_results();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_config(input logic [COUNT_W-1:0] value);
    settle_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    live_count = value;
    restart_tables();
  endtask

  function automatic ufe_item_t draw_item();
    ufe_item_t it;
    int lim;
    lim = in_use();
    it.cmd = ($urandom_range(0, 99) < 60) ? CMD_UNITE : CMD_QUERY;
    if ($urandom_range(0, 19) == 0) it.elem_a = ELEM_W'($urandom_range(0, 1023));
    else it.elem_a = ELEM_W'($urandom_range(0, lim - 1));
    if ($urandom_range(0, 9) == 0) it.elem_b = it.elem_a;
    else if ($urandom_range(0, 19) == 0) it.elem_b = ELEM_W'($urandom_range(0, 1023));
    else it.elem_b = ELEM_W'($urandom_range(0, lim - 1));
    return it;
  endfunction

  // Pairwise merges over a shuffled group build trees of full depth log2(n)
  task automatic unite_tournament(input int n);
    int order[MAX_ELEMENTS];
    int j;
    int tmp;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int stride = 1; stride < n; stride *= 2)
      for (int i = 0; i + stride < n; i += 2 * stride)
        send_cmd(CMD_UNITE, order[i], order[i + stride]);
    send_cmd(CMD_QUERY, order[n - 1], order[n / 2 - 1]);
    send_cmd(CMD_QUERY, order[n - 1], order[0]);
  endtask

  task automatic test_directed();
    send_cmd(CMD_UNITE, 0, 0);
    send_cmd(CMD_QUERY, 0, 1023);
    send_cmd(CMD_UNITE, 0, 1023);
    send_cmd(CMD_UNITE, 5, 0);
    send_cmd(CMD_QUERY, 1023, 5);
    send_cmd(CMD_UNITE, 1023, 0);
    send_cmd(CMD_UNITE, 682, 341);
    send_cmd(CMD_UNITE, 341, 5);
    write_config(COUNT_W'(4));
    send_cmd(CMD_QUERY, 4, 0);
    send_cmd(CMD_UNITE, 0, 4);
    send_cmd(CMD_UNITE, 1023, 1023);
    send_cmd(CMD_UNITE, 3, 2);
    write_config(COUNT_W'(0));
    send_cmd(CMD_UNITE, 0, 0);
    write_config(COUNT_W'(2047));
    send_cmd(CMD_UNITE, 1023, 0);
    send_cmd(CMD_QUERY, 0, 1023);
    write_config(COUNT_W'(1));
    send_cmd(CMD_QUERY, 0, 0);
    send_cmd(CMD_UNITE, 0, 1);
    write_config(ELEMENT_COUNT_RESET);
    send_cmd(CMD_QUERY, 1023, 1022);
  endtask

  task automatic test_deep_paths();
    write_config(COUNT_W'(64));
    unite_tournament(64);
  endtask

  // Long result stall while items keep coming, so the input side backs up
  task automatic test_backpressure();
    write_config(COUNT_W'(24));
    // start the hold once the clearing pass is over
    send_item(draw_item());
    hold_request = 300;
    repeat (9) send_item(draw_item());
    settle_results();
  endtask

  task automatic test_drain_pause();
    repeat (10) send_item(draw_item());
    settle_results();
    repeat (10) send_item(draw_item());
    settle_results();
  endtask

  task automatic test_random();
    int span;
    int kind;
    int burst;
    int group;
    bit steady;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) span = $urandom_range(2, 16);
      else if (kind < 8) span = $urandom_range(17, 128);
      else if (kind == 8) span = $urandom_range(129, 1024);
      else span = $urandom_range(1025, 2047);
      write_config(COUNT_W'(span));
      if ($urandom_range(0, 2) == 0) begin
        group = 2;
        while (group * 2 <= in_use() && group < 64) group *= 2;
        unite_tournament(group);
      end
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) hold_request = $urandom_range(50, 250);
      burst = $urandom_range(1, 24);
      repeat ($urandom_range(40, 120)) begin
        send_item(draw_item());
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 9) == 0) settle_results();
          else if (!steady) pause_sender($urandom_range(1, 16));
        end
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    item_if.valid  <= 1'b0;
    item_if.data   <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.data    <= '0;
    live_count = ELEMENT_COUNT_RESET;
    restart_tables();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_deep_paths();
    test_backpressure();
    test_drain_pause();
    test_random();
    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: a long hold when asked, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      rx_cycle++;
      case (rx_mode_e'((rx_cycle / 200) % 4))
        RX_OPEN:   result_if.ready <= 1'b1;
        RX_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: result_if.ready <= (rx_cycle % 4 == 0);
        default:   result_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    ufe_result_t want;
    ufe_result_t seen;
    if (rst_n && result_if.valid && result_if.ready) begin
      seen = result_if.data;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected transfer, root_a", int'(seen.root_a), 0);
      end else begin
        want = awaited_results.pop_front();
        if (seen.already_joined !== want.already_joined)
          report_mismatch("already_joined", int'(seen.already_joined),
                          int'(want.already_joined));
        if (seen.merged !== want.merged)
          report_mismatch("merged", int'(seen.merged), int'(want.merged));
        if (seen.root_a !== want.root_a)
          report_mismatch("root_a", int'(seen.root_a), int'(want.root_a));
        if (seen.set_size_a !== want.set_size_a)
          report_mismatch("set_size_a", int'(seen.set_size_a), int'(want.set_size_a));
        if (seen.bad_index !== want.bad_index)
          report_mismatch("bad_index", int'(seen.bad_index), int'(want.bad_index));
      end
      results_checked++;
    end
  end

  // Stop the run when no channel has seen a transfer for too long
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: watchdog expired after %0d cycles without a transfer", quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

endmodule
